/* rtl/pvs_pkg.sv */
// Shared types, constants and saturation helper for the polynomial value and slope block.
`timescale 1ns / 1ps

package pvs_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_W        = 16;
   localparam int NUM_COEFS     = 7;
   localparam int TERMS_W       = 3;
   localparam int CSR_IDX_W     = 4;
   localparam int DEF_MAX_TERMS = 7;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int RND_W         = PROD_W - FRAC_W;
   localparam int SUM_W         = RND_W + 1;

   typedef logic signed [DATA_W-1:0] q_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_ZERO  = 4'd0,
      CSR_COEF_ONE   = 4'd1,
      CSR_COEF_TWO   = 4'd2,
      CSR_COEF_THREE = 4'd3,
      CSR_COEF_FOUR  = 4'd4,
      CSR_COEF_FIVE  = 4'd5,
      CSR_COEF_SIX   = 4'd6,
      CSR_TERMS      = 4'd7
   } csr_idx_type;

   typedef struct packed {
      q_type q;
      logic  clip;
   } sat_type;

   // Round the Q32.32 product half up to Q16.16, add the other operand, clip to 32 bits.
   function automatic sat_type round_add_sat(input prod_type prod, input q_type b);
      prod_type rnd;
      sum_type  sum;
      sat_type  res;
      rnd = (prod + prod_type'(64'sd32768)) >>> FRAC_W;
      sum = sum_type'(signed'(rnd[RND_W-1:0])) + sum_type'(b);
      if (sum > sum_type'(q_type'({1'b0, {(DATA_W-1){1'b1}}}))) begin
         res.q    = {1'b0, {(DATA_W-1){1'b1}}};
         res.clip = 1'b1;
      end else if (sum < sum_type'(q_type'({1'b1, {(DATA_W-1){1'b0}}}))) begin
         res.q    = {1'b1, {(DATA_W-1){1'b0}}};
         res.clip = 1'b1;
      end else begin
         res.q    = sum[DATA_W-1:0];
         res.clip = 1'b0;
      end
      return res;
   endfunction

endpackage

/* rtl/polynomial_value_and_slope.sv */
// Top level: pipelined Horner evaluation of a polynomial and its first derivative.
`timescale 1ns / 1ps

// Usage
//  - Configuration: write coefficients c0..c6 (indexes 0..6) and the term count
//    (index 7) through csr_valid/csr_ready; csr_ready is always high. Indexes above
//    7 are dropped. Write only while no word is in flight.
//  - Input: a word (req_point_x, signed Q16.16) is taken at each edge where start
//    is high and busy is low. busy never rises, so one word may enter every cycle.
//  - Output: each result sits on rsp_poly_value, rsp_poly_slope and rsp_saturated
//    for one cycle with rsp_valid high. The receiver cannot stall, so the pipeline
//    never holds; results leave in input order.
//  - Pipeline: a word passes one entry register, then a multiply stage and a
//    round/add/clip stage for each of the MAX_TERMS-1 Horner steps; rsp_valid is
//    driven straight off the register of the last stage.
//    Throughput: one word per cycle.
//  - Every step runs for each word: coefficients at or above the term count read
//    as zero, so the leading steps carry zeros and the count only shapes the mask.
//  - Reset (synchronous, high) clears the coefficients, the term count and the valid flags and drops words in flight.
module polynomial_value_and_slope
   import pvs_pkg::*;
#(
   parameter int MAX_TERMS = DEF_MAX_TERMS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DATA_W-1:0]    req_point_x,
   output logic                 rsp_valid,
   output logic [DATA_W-1:0]    rsp_poly_value,
   output logic [DATA_W-1:0]    rsp_poly_slope,
   output logic                 rsp_saturated,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int STEPS = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;

   // configuration registers
   q_type               coef_ff [NUM_COEFS];
   logic [TERMS_W-1:0]  terms_ff;
   logic [TERMS_W-1:0]  terms_eff;
   q_type               coef_use [NUM_COEFS];

   // add stages: index 0 is the entry register, index k+1 the end of step k
   logic                st_valid_ff [MAX_TERMS];
   q_type               st_x_ff     [MAX_TERMS];
   q_type               st_p_ff     [MAX_TERMS];
   q_type               st_d_ff     [MAX_TERMS];
   logic                st_clip_ff  [MAX_TERMS];

   // multiply stages, one per step
   logic                m_valid_ff  [STEPS];
   q_type               m_x_ff      [STEPS];
   q_type               m_p_ff      [STEPS];
   prod_type            m_pp_ff     [STEPS];
   prod_type            m_dp_ff     [STEPS];
   logic                m_clip_ff   [STEPS];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
         terms_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_COEF_ZERO, CSR_COEF_ONE, CSR_COEF_TWO, CSR_COEF_THREE,
            CSR_COEF_FOUR, CSR_COEF_FIVE, CSR_COEF_SIX: begin
               coef_ff[csr_index[TERMS_W-1:0]] <= csr_wdata;
            end
            CSR_TERMS: begin
               terms_ff <= csr_wdata[TERMS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clamp the count to the pipeline depth and zero the unused coefficients
   always_comb begin
      terms_eff = (terms_ff > TERMS_W'(MAX_TERMS)) ? TERMS_W'(MAX_TERMS) : terms_ff;
      for (int i = 0; i < NUM_COEFS; i++) begin
         coef_use[i] = (TERMS_W'(i) < terms_eff) ? coef_ff[i] : '0;
      end
   end

   // entry: p starts at the top coefficient, d at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else begin
         st_valid_ff[0] <= start && !busy;
      end
      st_x_ff[0]    <= req_point_x;
      st_p_ff[0]    <= coef_use[MAX_TERMS-1];
      st_d_ff[0]    <= '0;
      st_clip_ff[0] <= 1'b0;
   end

   // Horner steps: d <- d*x + p, p <- p*x + c, top coefficient downward
   for (genvar k = 0; k < MAX_TERMS - 1; k++) begin : g_step
      localparam int CI = MAX_TERMS - 2 - k;
      sat_type p_res;
      sat_type d_res;

      // multiply stage: hold both full products and the old p
      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff[k] <= 1'b0;
         end else begin
            m_valid_ff[k] <= st_valid_ff[k];
         end
         m_x_ff[k]    <= st_x_ff[k];
         m_p_ff[k]    <= st_p_ff[k];
         m_clip_ff[k] <= st_clip_ff[k];
         m_pp_ff[k]   <= prod_type'(st_p_ff[k]) * prod_type'(st_x_ff[k]);
         m_dp_ff[k]   <= prod_type'(st_d_ff[k]) * prod_type'(st_x_ff[k]);
      end

      always_comb begin
         p_res = round_add_sat(m_pp_ff[k], coef_use[CI]);
         d_res = round_add_sat(m_dp_ff[k], m_p_ff[k]);
      end

      // round/add/clip stage: a clip anywhere sticks to the word
      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k+1] <= 1'b0;
         end else begin
            st_valid_ff[k+1] <= m_valid_ff[k];
         end
         st_x_ff[k+1]    <= m_x_ff[k];
         st_p_ff[k+1]    <= p_res.q;
         st_d_ff[k+1]    <= d_res.q;
         st_clip_ff[k+1] <= m_clip_ff[k] | p_res.clip | d_res.clip;
      end
   end

   // result port straight off the last stage
   assign rsp_valid      = st_valid_ff[MAX_TERMS-1];
   assign rsp_poly_value = st_p_ff[MAX_TERMS-1];
   assign rsp_poly_slope = st_d_ff[MAX_TERMS-1];
   assign rsp_saturated  = st_clip_ff[MAX_TERMS-1];

endmodule
